[src/hkmt_pkg.sv]
`default_nettype none

package hkmt_pkg;

    localparam int SLOT_W      = 8;
    localparam int HASH_W      = 64;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 200;  // slot + three hashes, already whole bytes
    localparam int M_TDATA_W   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_NONE      = 2'd0,
        ST_EXACT     = 2'd1,
        ST_LOWER     = 2'd2,
        ST_NAME_ONLY = 2'd3
    } status_t;

    typedef struct packed
    {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [HASH_W-1:0] name_hash;
        logic [HASH_W-1:0] type_hash;
        logic [HASH_W-1:0] lower_type_hash;
    } item_t;

    // head of the front queue as seen by the back end
    typedef struct packed
    {
        logic  valid;
        item_t item;
    } queue_head_t;

    // back end to front end
    typedef struct packed
    {
        logic pop;
        logic clearing;
    } back_ctl_t;

    // one table word; valid kept in memory so a clearing pass can reset it
    typedef struct packed
    {
        logic              valid;
        logic [HASH_W-1:0] lower_type_hash;
        logic [HASH_W-1:0] type_hash;
        logic [HASH_W-1:0] name_hash;
    } entry_t;

endpackage

`default_nettype wire

[src/hkmt_front.sv]
`default_nettype none

module hkmt_front
    import hkmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]           s_tuser,
    output queue_head_t               head,
    input  wire back_ctl_t            ctl
);

    localparam logic [31:0] DEPTH_W32 = 32'(TABLE_DEPTH);

    item_t             in_item;
    logic              in_keep;
    logic              accept;
    logic              push;

    item_t             q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        in_item.op              = op_t'(s_tuser[0]);
        in_item.slot            = s_tdata[7:0];
        in_item.name_hash       = s_tdata[71:8];
        in_item.type_hash       = s_tdata[135:72];
        in_item.lower_type_hash = s_tdata[199:136];
    end

    // loads beyond the table are taken and dropped here
    assign in_keep  = (in_item.op == OP_QUERY) || ({24'd0, in_item.slot} < DEPTH_W32);
    assign s_tready = !ctl.clearing && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && in_keep;

    assign head.valid = (count_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QCNT_W'(QUEUE_DEPTH)))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (count_reg != '0))
        else $error("queue pop while empty");

    a_hold_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clearing |-> !s_tready)
        else $error("beat taken during clearing pass");
`endif

endmodule

`default_nettype wire

[src/hkmt_back.sv]
`default_nettype none

module hkmt_back
    import hkmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire queue_head_t          head,
    output back_ctl_t                 ctl,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [STATUS_W-1:0]       m_tuser
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [4:0]
    {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  addr_next;

    entry_t            mem [TABLE_DEPTH];
    entry_t            rd_data_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [EXT_W-1:0]  slot_ext;

    logic              start;
    logic              res_load;
    logic [HASH_W-1:0] qname_reg;
    logic [HASH_W-1:0] qtype_reg;
    logic [HASH_W-1:0] qlower_reg;

    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              name_eq;
    logic              name_hit_reg;
    logic              exact_hit_reg;
    logic              lower_hit_reg;
    logic [IDX_W-1:0]  exact_at_reg;
    logic [IDX_W-1:0]  lower_at_reg;

    status_t           res_status;
    logic [EXT_W-1:0]  res_idx_ext;
    logic [SLOT_W-1:0] res_index;
    logic              out_vld_reg;
    status_t           out_status_reg;
    logic [SLOT_W-1:0] out_index_reg;

    assign slot_ext     = EXT_W'(head.item.slot);

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        wr_en        = 1'b0;
        wr_addr      = addr_reg;
        wr_data      = '0;
        rd_en        = 1'b0;
        ctl.pop      = 1'b0;
        ctl.clearing = (state_reg == S_CLEAR);
        start        = 1'b0;
        res_load     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (head.valid)
                begin
                    ctl.pop = 1'b1;
                    if (head.item.op == OP_LOAD)
                    begin
                        wr_en                   = 1'b1;
                        wr_addr                 = slot_ext[IDX_W-1:0];
                        wr_data.valid           = 1'b1;
                        wr_data.name_hash       = head.item.name_hash;
                        wr_data.type_hash       = head.item.type_hash;
                        wr_data.lower_type_hash = head.item.lower_type_hash;
                    end
                    else
                    begin
                        start      = 1'b1;
                        addr_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_en = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign name_eq = rd_data_reg.valid && (rd_data_reg.name_hash == qname_reg);

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= addr_reg;
        if (start)
        begin
            qname_reg  <= head.item.name_hash;
            qtype_reg  <= head.item.type_hash;
            qlower_reg <= head.item.lower_type_hash;
        end
        if (cmp_vld_reg && name_eq && !exact_hit_reg
            && (rd_data_reg.type_hash == qtype_reg))
        begin
            exact_at_reg <= cmp_idx_reg;
        end
        if (cmp_vld_reg && name_eq && !lower_hit_reg
            && (rd_data_reg.lower_type_hash == qlower_reg))
        begin
            lower_at_reg <= cmp_idx_reg;
        end
        if (res_load)
        begin
            out_status_reg <= res_status;
            out_index_reg  <= res_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            name_hit_reg  <= 1'b0;
            exact_hit_reg <= 1'b0;
            lower_hit_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            cmp_vld_reg <= rd_en;
            if (start)
            begin
                name_hit_reg  <= 1'b0;
                exact_hit_reg <= 1'b0;
                lower_hit_reg <= 1'b0;
            end
            else if (cmp_vld_reg && name_eq)
            begin
                name_hit_reg <= 1'b1;
                if (rd_data_reg.type_hash == qtype_reg)
                begin
                    exact_hit_reg <= 1'b1;
                end
                if (rd_data_reg.lower_type_hash == qlower_reg)
                begin
                    lower_hit_reg <= 1'b1;
                end
            end
            if (res_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        res_idx_ext = EXT_W'(exact_hit_reg ? exact_at_reg : lower_at_reg);
        res_index   = '0;
        if (exact_hit_reg)
        begin
            res_status = ST_EXACT;
            res_index  = res_idx_ext[SLOT_W-1:0];
        end
        else if (lower_hit_reg)
        begin
            res_status = ST_LOWER;
            res_index  = res_idx_ext[SLOT_W-1:0];
        end
        else if (name_hit_reg)
        begin
            res_status = ST_NAME_ONLY;
        end
        else
        begin
            res_status = ST_NONE;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_index_reg;
    assign m_tuser  = out_status_reg;

`ifndef SYNTH
    a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (state_reg == S_IDLE) && head.valid)
        else $error("queue popped outside idle");

    a_exact_needs_name: assert property (@(posedge clk) disable iff (!rst_n)
        (exact_hit_reg || lower_hit_reg) |-> name_hit_reg)
        else $error("type hit without name hit");

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == S_SCAN) || (state_reg == S_DRAIN))
        else $error("compare stage active outside scan");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_vld_reg || m_tready))
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

[src/hash_key_match_table.sv]
`default_nettype none

// Channel  Dir  Handshake         Payload
// s_       in   s_tvalid/s_tready s_tuser: operation; s_tdata: entry_index, name_hash,
//                                 type_hash, lower_type_hash
// m_       out  m_tvalid/m_tready m_tuser: match_status; m_tdata: match_index
//
// A load beat is a single table write in the back end.
// A query beat reads the table one entry per cycle through the single registered
// read port, then passes the compare stage and the result register.
// After reset a clearing pass writes every entry invalid, with s_tready low until it
// ends. A 2-deep queue decouples intake from the table scan, and a result
// register lets the next beats in while a result waits on m_tready.
module hash_key_match_table
    import hkmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [7:0] entry_index, [71:8] name_hash, [135:72] type_hash,
    // [199:136] lower_type_hash
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] operation (0 load, 1 query)
    input  wire logic [0:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [7:0] match_index
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [1:0] match_status
    output logic [STATUS_W-1:0]       m_tuser
);

    queue_head_t head;   // next classified beat for the back end
    back_ctl_t   ctl;    // pop and clearing-pass flag back to intake

    hkmt_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .ctl      (ctl)
    );

    hkmt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .ctl      (ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
